### sv/assert_macros.svh
// shared assertion helpers, clocked on clk and disabled while rst_n is low
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define CHK_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define CHK_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/utf8s_pkg.sv
package utf8s_pkg;

  localparam int MAX_TOKENS = 4;
  localparam int TOK_CNT_W = 3;
  localparam int TOK_IDX_W = 2;
  localparam int CMD_FIFO_DEPTH_DEF = 2;

  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;
  localparam logic [PADDR_W-1:0] REG_STRIP_BOM_ADDR = 3'd0;

  localparam logic [7:0] BYTE_LF = 8'h0A;
  localparam logic [7:0] BYTE_CR = 8'h0D;
  localparam logic [7:0] REPL_B0 = 8'hEF;
  localparam logic [7:0] REPL_B1 = 8'hBF;
  localparam logic [7:0] REPL_B2 = 8'hBD;
  localparam logic [7:0] BOM_B0 = 8'hEF;
  localparam logic [7:0] BOM_B1 = 8'hBB;
  localparam logic [7:0] BOM_B2 = 8'hBF;

  localparam logic [20:0] CP_MAX = 21'h10FFFF;
  localparam logic [20:0] SURR_LO = 21'h00D800;
  localparam logic [20:0] SURR_HI = 21'h00DFFF;
  localparam logic [20:0] MIN_2B = 21'h000080;
  localparam logic [20:0] MIN_3B = 21'h000800;
  localparam logic [20:0] MIN_4B = 21'h010000;

  // one output token: a literal byte or a whole U+FFFD repair
  typedef struct packed {
    logic       is_repl;
    logic       is_lf;
    logic [7:0] data;
  } tok_t;

  // everything one input word produces
  typedef struct packed {
    tok_t [MAX_TOKENS-1:0]  toks;
    logic [TOK_CNT_W-1:0]   ntok;
  } cmd_t;

  localparam tok_t REPL_TOK = '{is_repl: 1'b1, is_lf: 1'b0, data: 8'h00};
  localparam tok_t LF_TOK   = '{is_repl: 1'b0, is_lf: 1'b1, data: BYTE_LF};

  // sequence length wanted by a lead byte, zero for a bad lead
  function automatic logic [2:0] want_len(input logic [7:0] lead);
    logic [2:0] len;
    if (lead[7:5] == 3'b110) len = 3'd2;
    else if (lead[7:4] == 4'b1110) len = 3'd3;
    else if (lead[7:3] == 5'b11110) len = 3'd4;
    else len = 3'd0;
    return len;
  endfunction

endpackage

### sv/utf8s_front.sv
module utf8s_front (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept_i,
  input  logic [7:0]        byte_i,
  input  logic              eos_i,
  input  logic              strip_bom_i,
  output logic              push_o,
  output utf8s_pkg::cmd_t   cmd_o
);
  import utf8s_pkg::*;

  logic [1:0] hc_r, hc_nxt;
  logic       cr_r, cr_nxt;
  logic       start_r, start_nxt;
  logic [7:0] held_r [3];
  logic [7:0] held_nxt [3];

  tok_t [MAX_TOKENS-1:0] toks;
  logic [TOK_CNT_W-1:0]  ntok;

  always_comb begin
    logic [2:0]  seq_len;
    logic [20:0] acc;
    logic [20:0] acc_min;
    logic        bad;
    logic        is_bom;
    logic        fresh;
    logic        skip;
    tok_t        lit;

    hc_nxt    = hc_r;
    cr_nxt    = cr_r;
    start_nxt = start_r;
    held_nxt  = held_r;
    toks      = '0;
    ntok      = '0;
    fresh     = 1'b0;
    skip      = 1'b0;
    seq_len   = {1'b0, hc_r} + 3'd1;
    acc       = '0;
    acc_min   = '0;
    bad       = 1'b0;
    is_bom    = 1'b0;
    lit       = '0;

    if (hc_r != 2'd0) begin
      if (byte_i[7:6] == 2'b10) begin
        if (seq_len >= want_len(held_r[0])) begin
          // sequence complete: decode and check the code point
          case (seq_len)
            3'd2: begin
              acc     = {10'd0, held_r[0][4:0], byte_i[5:0]};
              acc_min = MIN_2B;
            end
            3'd3: begin
              acc     = {5'd0, held_r[0][3:0], held_r[1][5:0], byte_i[5:0]};
              acc_min = MIN_3B;
            end
            default: begin
              acc     = {held_r[0][2:0], held_r[1][5:0], held_r[2][5:0], byte_i[5:0]};
              acc_min = MIN_4B;
            end
          endcase
          bad = (acc < acc_min) || (acc > CP_MAX) || ((acc >= SURR_LO) && (acc <= SURR_HI));
          is_bom = start_r && strip_bom_i && (seq_len == 3'd3) && (held_r[0] == BOM_B0)
                   && (held_r[1] == BOM_B1) && (byte_i == BOM_B2);
          if (bad) begin
            for (int k = 0; k < 4; k++) begin
              if (k < int'(seq_len)) begin
                toks[ntok[TOK_IDX_W-1:0]] = REPL_TOK;
                ntok = ntok + 3'd1;
              end
            end
          end else if (!is_bom) begin
            for (int k = 0; k < 3; k++) begin
              if (k < int'(hc_r)) begin
                lit = '{is_repl: 1'b0, is_lf: 1'b0, data: held_r[k]};
                toks[ntok[TOK_IDX_W-1:0]] = lit;
                ntok = ntok + 3'd1;
              end
            end
            lit = '{is_repl: 1'b0, is_lf: 1'b0, data: byte_i};
            toks[ntok[TOK_IDX_W-1:0]] = lit;
            ntok = ntok + 3'd1;
          end
          hc_nxt    = 2'd0;
          start_nxt = 1'b0;
        end else begin
          held_nxt[hc_r] = byte_i;
          hc_nxt         = hc_r + 2'd1;
        end
      end else begin
        // broken sequence: one repair per held byte, then rescan
        for (int k = 0; k < 3; k++) begin
          if (k < int'(hc_r)) begin
            toks[ntok[TOK_IDX_W-1:0]] = REPL_TOK;
            ntok = ntok + 3'd1;
          end
        end
        hc_nxt    = 2'd0;
        start_nxt = 1'b0;
        fresh     = 1'b1;
      end
    end else begin
      fresh = 1'b1;
    end

    if (fresh) begin
      if (cr_nxt) begin
        cr_nxt = 1'b0;
        toks[ntok[TOK_IDX_W-1:0]] = LF_TOK;
        ntok = ntok + 3'd1;
        skip = (byte_i == BYTE_LF);
      end
      if (!skip) begin
        if (byte_i == BYTE_CR) begin
          cr_nxt    = 1'b1;
          start_nxt = 1'b0;
        end else if (!byte_i[7]) begin
          lit = '{is_repl: 1'b0, is_lf: (byte_i == BYTE_LF), data: byte_i};
          toks[ntok[TOK_IDX_W-1:0]] = lit;
          ntok = ntok + 3'd1;
          start_nxt = 1'b0;
        end else if (want_len(byte_i) == 3'd0) begin
          toks[ntok[TOK_IDX_W-1:0]] = REPL_TOK;
          ntok = ntok + 3'd1;
          start_nxt = 1'b0;
        end else begin
          held_nxt[0] = byte_i;
          hc_nxt      = 2'd1;
        end
      end
    end

    if (eos_i) begin
      // flush a cut-off sequence and a waiting carriage return
      for (int k = 0; k < 3; k++) begin
        if (k < int'(hc_nxt)) begin
          toks[ntok[TOK_IDX_W-1:0]] = REPL_TOK;
          ntok = ntok + 3'd1;
        end
      end
      if (cr_nxt) begin
        toks[ntok[TOK_IDX_W-1:0]] = LF_TOK;
        ntok = ntok + 3'd1;
      end
      hc_nxt    = 2'd0;
      cr_nxt    = 1'b0;
      start_nxt = 1'b1;
    end
  end

  assign cmd_o.toks = toks;
  assign cmd_o.ntok = ntok;
  assign push_o     = accept_i && (ntok != '0);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hc_r    <= 2'd0;
      cr_r    <= 1'b0;
      start_r <= 1'b1;
    end else if (accept_i) begin
      hc_r    <= hc_nxt;
      cr_r    <= cr_nxt;
      start_r <= start_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept_i) begin
      held_r <= held_nxt;
    end
  end

endmodule

### sv/utf8s_cmd_fifo.sv
`include "assert_macros.svh"

module utf8s_cmd_fifo #(
  parameter int DEPTH = utf8s_pkg::CMD_FIFO_DEPTH_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              wr_i,
  input  utf8s_pkg::cmd_t   wr_data_i,
  input  logic              rd_i,
  output utf8s_pkg::cmd_t   rd_data_o,
  output logic              empty_o,
  output logic              full_o
);
  import utf8s_pkg::*;

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(DEPTH);

  cmd_t             slot_r [DEPTH];
  logic [PTR_W-1:0] wp_r, rp_r;
  logic [CNT_W-1:0] cnt_r;

  assign empty_o   = (cnt_r == '0);
  assign full_o    = (cnt_r == FULL_CNT);
  assign rd_data_o = slot_r[rp_r];

  always_ff @(posedge clk) begin
    if (wr_i) begin
      slot_r[wp_r] <= wr_data_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (wr_i) begin
        wp_r <= (wp_r == LAST_PTR) ? '0 : wp_r + PTR_W'(1);
      end
      if (rd_i) begin
        rp_r <= (rp_r == LAST_PTR) ? '0 : rp_r + PTR_W'(1);
      end
      if (wr_i && !rd_i) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (rd_i && !wr_i) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
  end

  `CHK_NOW(a_no_overflow, wr_i, !full_o, "command queue written while full")
  `CHK_NOW(a_no_underflow, rd_i, !empty_o, "command queue read while empty")
  `CHK_NEXT(a_cnt_up, wr_i && !rd_i, cnt_r == $past(cnt_r) + CNT_W'(1), "queue count lost a word")

endmodule

### sv/utf8s_back.sv
`include "assert_macros.svh"

module utf8s_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cmd_avail_i,
  input  utf8s_pkg::cmd_t   cmd_i,
  output logic              cmd_take_o,
  input  logic              pop_i,
  output logic              empty_o,
  output logic [7:0]        byte_o,
  output logic              last_o,
  output logic              repl_o,
  output logic              lf_o
);
  import utf8s_pkg::*;

  cmd_t                 cur_r;
  logic                 busy_r;
  logic [TOK_IDX_W-1:0] tix_r;
  logic [1:0]           sub_r;

  tok_t tok;
  logic tok_last;
  logic run_last;
  logic take;

  assign tok      = cur_r.toks[tix_r];
  assign tok_last = !tok.is_repl || (sub_r == 2'd2);
  assign run_last = tok_last && (({1'b0, tix_r} + 3'd1) == cur_r.ntok);
  assign take     = cmd_avail_i && (!busy_r || (pop_i && run_last));

  always_comb begin
    if (tok.is_repl) begin
      case (sub_r)
        2'd0:    byte_o = REPL_B0;
        2'd1:    byte_o = REPL_B1;
        default: byte_o = REPL_B2;
      endcase
    end else begin
      byte_o = tok.data;
    end
  end

  assign empty_o    = !busy_r;
  assign last_o     = run_last;
  assign repl_o     = tok.is_repl;
  assign lf_o       = tok.is_lf;
  assign cmd_take_o = take;

  always_ff @(posedge clk) begin
    if (take) begin
      cur_r <= cmd_i;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      tix_r  <= '0;
      sub_r  <= 2'd0;
    end else if (take) begin
      busy_r <= 1'b1;
      tix_r  <= '0;
      sub_r  <= 2'd0;
    end else if (pop_i && busy_r) begin
      if (run_last) begin
        busy_r <= 1'b0;
      end else if (tok_last) begin
        tix_r <= tix_r + TOK_IDX_W'(1);
        sub_r <= 2'd0;
      end else begin
        sub_r <= sub_r + 2'd1;
      end
    end
  end

  `CHK_NOW(a_tix_in_run, busy_r, ({1'b0, tix_r} < cur_r.ntok), "token index beyond run")
  `CHK_NOW(a_sub_only_repl, busy_r && (sub_r != 2'd0), tok.is_repl, "sub-byte on a literal")
  `CHK_NEXT(a_run_holds, pop_i && busy_r && !run_last, busy_r, "run dropped before its end")

endmodule

### sv/utf8_sanitize_newline_normalize_core.sv
// channel   | handshake            | payload
// ----------+----------------------+---------------------------------------------
// input     | push / full          | in_byte, in_end_of_stream
// result    | pop / empty          | out_byte, out_last_of_run, out_is_replacement,
//           |                      | out_is_line_end
// config    | psel/penable/pwrite  | paddr, pwdata, prdata (pready tied high)
//
// one raw word is taken per cycle while the command queue has room; each word
// turns into a command of up to four tokens in the same cycle
// the back end sends one result word per cycle while pop is asserted, so a word with
// k result bytes holds it until all k are popped (up to 12 on a burst of repairs)
// full rises once CMD_FIFO_DEPTH commands wait behind a stalled result side
// rst_n is synchronous: decoder state, queue and output run clear, and
// byte order mark stripping comes up enabled
module utf8_sanitize_newline_normalize_core #(
  parameter int CMD_FIFO_DEPTH = utf8s_pkg::CMD_FIFO_DEPTH_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // input word channel
  input  logic                          push,
  output logic                          full,
  input  logic [7:0]                    in_byte,
  input  logic                          in_end_of_stream,
  // result word channel
  output logic                          empty,
  input  logic                          pop,
  output logic [7:0]                    out_byte,
  output logic                          out_last_of_run,
  output logic                          out_is_replacement,
  output logic                          out_is_line_end,
  // register port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [utf8s_pkg::PADDR_W-1:0] paddr,
  input  logic [utf8s_pkg::PDATA_W-1:0] pwdata,
  output logic [utf8s_pkg::PDATA_W-1:0] prdata,
  output logic                          pready
);
  import utf8s_pkg::*;

  logic strip_bom_r;
  logic accept;
  logic fe_push;
  cmd_t fe_cmd;
  cmd_t q_cmd;
  logic q_empty;
  logic q_full;
  logic be_take;

  // register port: no wait states, only the strip flag is defined
  assign pready = 1'b1;
  assign prdata = (paddr == REG_STRIP_BOM_ADDR) ? {{(PDATA_W-1){1'b0}}, strip_bom_r} : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strip_bom_r <= 1'b1;
    end else if (psel && penable && pwrite && (paddr == REG_STRIP_BOM_ADDR)) begin
      strip_bom_r <= pwdata[0];
    end
  end

  // a word is taken whenever the queue can hold what it might produce
  assign full   = q_full;
  assign accept = push && !q_full;

  // front end: decoder state, line-ending fold, byte order mark strip, repair decisions
  utf8s_front u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept_i    (accept),
    .byte_i      (in_byte),
    .eos_i       (in_end_of_stream),
    .strip_bom_i (strip_bom_r),
    .push_o      (fe_push),
    .cmd_o       (fe_cmd)
  );

  // short command queue decouples the two sides
  utf8s_cmd_fifo #(
    .DEPTH (CMD_FIFO_DEPTH)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .wr_i      (fe_push),
    .wr_data_i (fe_cmd),
    .rd_i      (be_take),
    .rd_data_o (q_cmd),
    .empty_o   (q_empty),
    .full_o    (q_full)
  );

  // back end: expands tokens into result words, repairs into three bytes
  utf8s_back u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd_avail_i (!q_empty),
    .cmd_i       (q_cmd),
    .cmd_take_o  (be_take),
    .pop_i       (pop),
    .empty_o     (empty),
    .byte_o      (out_byte),
    .last_o      (out_last_of_run),
    .repl_o      (out_is_replacement),
    .lf_o        (out_is_line_end)
  );

endmodule
